// ===== rtl/ntoe_pkg.sv =====
package ntoe_pkg;

    localparam int unsigned CAPACITY_DEF = 32;

    localparam logic [1:0] FN_OBSERVE = 2'd0;
    localparam logic [1:0] FN_NAME    = 2'd1;
    localparam logic [1:0] FN_READ    = 2'd2;
    localparam logic [1:0] FN_SPARE   = 2'd3;

    localparam int FLAG_HOPS_BIT  = 0;
    localparam int FLAG_NAMED_BIT = 1;

    typedef struct packed {
        logic [31:0] id;
        logic [31:0] seen;
        logic [15:0] rssi;
        logic [7:0]  snr;
        logic [31:0] pkts;
        logic [7:0]  hops;
        logic [1:0]  flags;
    } entry_t;

    typedef struct packed {
        logic       added;
        logic       valid_res;
        entry_t     rec;
        logic [5:0] occupancy;
    } res_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LK_RD,
        ST_LK_WAIT,
        ST_RK_RD,
        ST_RK_WAIT,
        ST_FINISH
    } state_t;

endpackage

// ===== rtl/node_table_oldest_eviction.sv =====
// Channel  Handshake             Payload
// in       in_valid / in_ready   func node_id now_time rssi_in snr_in hop_origin
//                                hop_remain name_present rank_index
// out      out_valid / out_ready added valid_res entry_* occupancy
//
// Observe/name: streaming id scan of the table RAM, then one read, one write-back and
// the result. Read by rank: each candidate is read, then ranked by a scan of the
// table, all through the single read port. Reset clears state and count; table RAM
// needs no clearing. Output register holds a result until out_ready; input is still
// accepted while a result waits there, and the next result waits in the controller.
module node_table_oldest_eviction
    import ntoe_pkg::*;
    #(
        parameter int unsigned CAPACITY = CAPACITY_DEF
    )
    (
        input  logic               clk,
        input  logic               rst_n,
        input  logic               in_valid,
        output logic               in_ready,
        input  logic [1:0]         func,
        input  logic [31:0]        node_id,
        input  logic [31:0]        now_time,
        input  logic signed [15:0] rssi_in,
        input  logic signed [7:0]  snr_in,
        input  logic [2:0]         hop_origin,
        input  logic [2:0]         hop_remain,
        input  logic               name_present,
        input  logic [4:0]         rank_index,
        output logic               out_valid,
        input  logic               out_ready,
        output logic               added,
        output logic               valid_res,
        output logic [31:0]        entry_id,
        output logic signed [15:0] entry_rssi,
        output logic signed [7:0]  entry_snr,
        output logic [31:0]        entry_seen,
        output logic [31:0]        entry_packets,
        output logic [7:0]         entry_hops,
        output logic               entry_has_hops,
        output logic               entry_named,
        output logic [5:0]         occupancy
    );

    localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

    logic             ram_re;
    logic             ram_we;
    logic [IDX_W-1:0] ram_raddr;
    logic [IDX_W-1:0] ram_waddr;
    entry_t           ram_rdata;
    entry_t           ram_wdata;

    logic res_valid;
    logic res_take;
    res_t res;

    logic out_valid_reg, out_valid_next;
    res_t out_reg, out_next;

    ntoe_ram
        #(
            .WIDTH  ($bits(entry_t)),
            .DEPTH  (CAPACITY),
            .ADDR_W (IDX_W)
        )
    u_ram
        (
            .clk   (clk),
            .we    (ram_we),
            .waddr (ram_waddr),
            .wdata (ram_wdata),
            .re    (ram_re),
            .raddr (ram_raddr),
            .rdata (ram_rdata)
        );

    ntoe_ctrl
        #(
            .CAPACITY (CAPACITY),
            .IDX_W    (IDX_W),
            .CNT_W    (CNT_W)
        )
    u_ctrl
        (
            .clk          (clk),
            .rst_n        (rst_n),
            .in_valid     (in_valid),
            .in_ready     (in_ready),
            .func         (func),
            .node_id      (node_id),
            .now_time     (now_time),
            .rssi_in      (rssi_in),
            .snr_in       (snr_in),
            .hop_origin   (hop_origin),
            .hop_remain   (hop_remain),
            .name_present (name_present),
            .rank_index   (rank_index),
            .res_valid    (res_valid),
            .res_take     (res_take),
            .res          (res),
            .ram_re       (ram_re),
            .ram_raddr    (ram_raddr),
            .ram_rdata    (ram_rdata),
            .ram_we       (ram_we),
            .ram_waddr    (ram_waddr),
            .ram_wdata    (ram_wdata)
        );

    assign res_take = res_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (res_take)
        begin
            out_next       = res;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid      = out_valid_reg;
    assign added          = out_reg.added;
    assign valid_res      = out_reg.valid_res;
    assign entry_id       = out_reg.rec.id;
    assign entry_rssi     = out_reg.rec.rssi;
    assign entry_snr      = out_reg.rec.snr;
    assign entry_seen     = out_reg.rec.seen;
    assign entry_packets  = out_reg.rec.pkts;
    assign entry_hops     = out_reg.rec.hops;
    assign entry_has_hops = out_reg.rec.flags[FLAG_HOPS_BIT];
    assign entry_named    = out_reg.rec.flags[FLAG_NAMED_BIT];
    assign occupancy      = out_reg.occupancy;

endmodule

// ===== rtl/ntoe_ram.sv =====
module ntoe_ram
    #(
        parameter int unsigned WIDTH  = 8,
        parameter int unsigned DEPTH  = 32,
        parameter int unsigned ADDR_W = 5
    )
    (
        input  logic              clk,
        input  logic              we,
        input  logic [ADDR_W-1:0] waddr,
        input  logic [WIDTH-1:0]  wdata,
        input  logic              re,
        input  logic [ADDR_W-1:0] raddr,
        output logic [WIDTH-1:0]  rdata
    );

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/ntoe_ctrl.sv =====
module ntoe_ctrl
    import ntoe_pkg::*;
    #(
        parameter int unsigned CAPACITY = CAPACITY_DEF,
        parameter int unsigned IDX_W    = 5,
        parameter int unsigned CNT_W    = 6
    )
    (
        input  logic                clk,
        input  logic                rst_n,
        input  logic                in_valid,
        output logic                in_ready,
        input  logic [1:0]          func,
        input  logic [31:0]         node_id,
        input  logic [31:0]         now_time,
        input  logic signed [15:0]  rssi_in,
        input  logic signed [7:0]   snr_in,
        input  logic [2:0]          hop_origin,
        input  logic [2:0]          hop_remain,
        input  logic                name_present,
        input  logic [4:0]          rank_index,
        output logic                res_valid,
        input  logic                res_take,
        output res_t                res,
        output logic                ram_re,
        output logic [IDX_W-1:0]    ram_raddr,
        input  entry_t              ram_rdata,
        output logic                ram_we,
        output logic [IDX_W-1:0]    ram_waddr,
        output entry_t              ram_wdata
    );

    localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    state_t state_reg, state_next;

    logic [1:0]       func_reg, func_next;
    logic [31:0]      id_reg, id_next;
    logic [31:0]      now_reg, now_next;
    logic [15:0]      rssi_reg, rssi_next;
    logic [7:0]       snr_reg, snr_next;
    logic [2:0]       hstart_reg, hstart_next;
    logic [2:0]       hlimit_reg, hlimit_next;
    logic             named_reg, named_next;
    logic [4:0]       rank_reg, rank_next;

    logic [CNT_W-1:0] used_reg, used_next;
    logic [CNT_W-1:0] scan_addr_reg, scan_addr_next;
    logic             pipe_vld_reg, pipe_vld_next;
    logic [IDX_W-1:0] pipe_idx_reg, pipe_idx_next;
    logic             hit_reg, hit_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic [IDX_W-1:0] vic_idx_reg, vic_idx_next;
    logic [31:0]      vic_seen_reg, vic_seen_next;
    logic [IDX_W-1:0] slot_reg, slot_next;
    logic             new_reg, new_next;
    logic [CNT_W-1:0] cur_i_reg, cur_i_next;
    entry_t           cur_rec_reg, cur_rec_next;
    logic [CNT_W-1:0] ahead_reg, ahead_next;
    logic             added_reg, added_next;
    logic             vres_reg, vres_next;
    entry_t           rec_out_reg, rec_out_next;

    logic             scan_done;
    logic [CNT_W-1:0] cur_i_inc;
    entry_t           mod_rec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            used_reg     <= '0;
            pipe_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            used_reg     <= used_next;
            pipe_vld_reg <= pipe_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg      <= func_next;
        id_reg        <= id_next;
        now_reg       <= now_next;
        rssi_reg      <= rssi_next;
        snr_reg       <= snr_next;
        hstart_reg    <= hstart_next;
        hlimit_reg    <= hlimit_next;
        named_reg     <= named_next;
        rank_reg      <= rank_next;
        scan_addr_reg <= scan_addr_next;
        pipe_idx_reg  <= pipe_idx_next;
        hit_reg       <= hit_next;
        hit_idx_reg   <= hit_idx_next;
        vic_idx_reg   <= vic_idx_next;
        vic_seen_reg  <= vic_seen_next;
        slot_reg      <= slot_next;
        new_reg       <= new_next;
        cur_i_reg     <= cur_i_next;
        cur_rec_reg   <= cur_rec_next;
        ahead_reg     <= ahead_next;
        added_reg     <= added_next;
        vres_reg      <= vres_next;
        rec_out_reg   <= rec_out_next;
    end

    assign scan_done = (scan_addr_reg >= used_reg) && !pipe_vld_reg;
    assign cur_i_inc = cur_i_reg + CNT_W'(1);

    // read-modify-write of the claimed or found entry
    always_comb
    begin
        if (new_reg)
        begin
            mod_rec    = '0;
            mod_rec.id = id_reg;
        end
        else
        begin
            mod_rec = ram_rdata;
        end
        if (func_reg == FN_OBSERVE)
        begin
            mod_rec.rssi = rssi_reg;
            mod_rec.snr  = snr_reg;
            mod_rec.seen = now_reg;
            mod_rec.pkts = mod_rec.pkts + 32'd1;
            if (hstart_reg != 3'd0)
            begin
                mod_rec.hops                 = {5'd0, hstart_reg} - {5'd0, hlimit_reg};
                mod_rec.flags[FLAG_HOPS_BIT] = 1'b1;
            end
        end
        else
        begin
            if (new_reg)
            begin
                mod_rec.seen = now_reg;
            end
            if (named_reg)
            begin
                mod_rec.flags[FLAG_NAMED_BIT] = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        func_next      = func_reg;
        id_next        = id_reg;
        now_next       = now_reg;
        rssi_next      = rssi_reg;
        snr_next       = snr_reg;
        hstart_next    = hstart_reg;
        hlimit_next    = hlimit_reg;
        named_next     = named_reg;
        rank_next      = rank_reg;
        used_next      = used_reg;
        scan_addr_next = scan_addr_reg;
        pipe_vld_next  = pipe_vld_reg;
        pipe_idx_next  = pipe_idx_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        vic_idx_next   = vic_idx_reg;
        vic_seen_next  = vic_seen_reg;
        slot_next      = slot_reg;
        new_next       = new_reg;
        cur_i_next     = cur_i_reg;
        cur_rec_next   = cur_rec_reg;
        ahead_next     = ahead_reg;
        added_next     = added_reg;
        vres_next      = vres_reg;
        rec_out_next   = rec_out_reg;

        in_ready  = 1'b0;
        res_valid = 1'b0;
        ram_re    = 1'b0;
        ram_raddr = '0;
        ram_we    = 1'b0;
        ram_waddr = slot_reg;
        ram_wdata = mod_rec;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    func_next      = func;
                    id_next        = node_id;
                    now_next       = now_time;
                    rssi_next      = rssi_in;
                    snr_next       = snr_in;
                    hstart_next    = hop_origin;
                    hlimit_next    = hop_remain;
                    named_next     = name_present;
                    rank_next      = rank_index;
                    added_next     = 1'b0;
                    vres_next      = 1'b0;
                    rec_out_next   = '0;
                    scan_addr_next = '0;
                    pipe_vld_next  = 1'b0;
                    hit_next       = 1'b0;
                    cur_i_next     = '0;
                    if ((func == FN_OBSERVE || func == FN_NAME) && node_id != 32'd0)
                    begin
                        state_next = ST_SCAN;
                    end
                    else if (func == FN_READ && CMP_W'(rank_index) < CMP_W'(used_reg))
                    begin
                        state_next = ST_RK_RD;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_SCAN:
            begin
                if (scan_addr_reg < used_reg)
                begin
                    ram_re         = 1'b1;
                    ram_raddr      = scan_addr_reg[IDX_W-1:0];
                    scan_addr_next = scan_addr_reg + CNT_W'(1);
                    pipe_vld_next  = 1'b1;
                    pipe_idx_next  = scan_addr_reg[IDX_W-1:0];
                end
                else
                begin
                    pipe_vld_next = 1'b0;
                end
                if (pipe_vld_reg)
                begin
                    if (func_reg == FN_READ)
                    begin
                        if ((CNT_W'(pipe_idx_reg) != cur_i_reg) &&
                            ((ram_rdata.seen > cur_rec_reg.seen) ||
                             (ram_rdata.seen == cur_rec_reg.seen &&
                              CNT_W'(pipe_idx_reg) < cur_i_reg)))
                        begin
                            ahead_next = ahead_reg + CNT_W'(1);
                        end
                    end
                    else
                    begin
                        if (!hit_reg && ram_rdata.id == id_reg)
                        begin
                            hit_next     = 1'b1;
                            hit_idx_next = pipe_idx_reg;
                        end
                        if (pipe_idx_reg == '0 || ram_rdata.seen < vic_seen_reg)
                        begin
                            vic_idx_next  = pipe_idx_reg;
                            vic_seen_next = ram_rdata.seen;
                        end
                    end
                end
                if (scan_done)
                begin
                    if (func_reg == FN_READ)
                    begin
                        if (CMP_W'(ahead_reg) == CMP_W'(rank_reg))
                        begin
                            vres_next    = 1'b1;
                            rec_out_next = cur_rec_reg;
                            state_next   = ST_FINISH;
                        end
                        else if (cur_i_inc >= used_reg)
                        begin
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            cur_i_next = cur_i_inc;
                            state_next = ST_RK_RD;
                        end
                    end
                    else
                    begin
                        state_next = ST_LK_RD;
                    end
                end
            end

            ST_LK_RD:
            begin
                new_next = !hit_reg;
                if (hit_reg)
                begin
                    slot_next = hit_idx_reg;
                end
                else if (used_reg < CAP_CNT)
                begin
                    slot_next = used_reg[IDX_W-1:0];
                    used_next = used_reg + CNT_W'(1);
                end
                else
                begin
                    slot_next = vic_idx_reg;
                end
                ram_re     = 1'b1;
                ram_raddr  = slot_next;
                state_next = ST_LK_WAIT;
            end

            ST_LK_WAIT:
            begin
                ram_we     = 1'b1;
                added_next = new_reg && (func_reg == FN_OBSERVE);
                state_next = ST_FINISH;
            end

            ST_RK_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = cur_i_reg[IDX_W-1:0];
                state_next = ST_RK_WAIT;
            end

            ST_RK_WAIT:
            begin
                cur_rec_next   = ram_rdata;
                scan_addr_next = '0;
                pipe_vld_next  = 1'b0;
                ahead_next     = '0;
                state_next     = ST_SCAN;
            end

            ST_FINISH:
            begin
                res_valid = 1'b1;
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res.added     = added_reg;
        res.valid_res = vres_reg;
        res.rec       = rec_out_reg;
        res.occupancy = 6'(used_reg);
    end

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CAP_CNT)
        else $error("occupancy above capacity");

    a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_re && ram_we))
        else $error("read and write in one cycle");

    a_wait_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LK_WAIT) |-> $past(state_reg == ST_LK_RD))
        else $error("write-back without preceding read");

    a_vres_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && vres_reg) |-> (func_reg == FN_READ))
        else $error("entry returned for non-read transaction");

endmodule

// ===== test/node_table_oldest_eviction_check.sv =====
module node_table_oldest_eviction_check
    import ntoe_pkg::*;
    (
        input  logic               clk,
        input  logic               rst_n,
        input  logic               in_valid,
        input  logic               in_ready,
        input  logic [1:0]         func,
        input  logic [31:0]        node_id,
        input  logic [31:0]        now_time,
        input  logic signed [15:0] rssi_in,
        input  logic signed [7:0]  snr_in,
        input  logic [2:0]         hop_origin,
        input  logic [2:0]         hop_remain,
        input  logic               name_present,
        input  logic [4:0]         rank_index,
        input  logic               out_valid,
        input  logic               out_ready,
        input  logic               added,
        input  logic               valid_res,
        input  logic [31:0]        entry_id,
        input  logic signed [15:0] entry_rssi,
        input  logic signed [7:0]  entry_snr,
        input  logic [31:0]        entry_seen,
        input  logic [31:0]        entry_packets,
        input  logic [7:0]         entry_hops,
        input  logic               entry_has_hops,
        input  logic               entry_named,
        input  logic [5:0]         occupancy,
        output int                 errors,
        output int                 pending
    );

    localparam int CAP = CAPACITY_DEF;

    entry_t     table_m [CAP];
    int         used_m;
    res_t       answers [$];

    assign pending = answers.size();

    function automatic int find_slot(logic [31:0] id);
        for (int i = 0; i < used_m; i++)
            if (table_m[i].id == id) return i;
        return -1;
    endfunction

    function automatic int claim_slot(logic [31:0] id);
        int slot;
        slot = 0;
        if (used_m < CAP) begin
            slot = used_m;
            used_m++;
        end else begin
            for (int i = 1; i < used_m; i++)
                if (table_m[i].seen < table_m[slot].seen) slot = i;
        end
        table_m[slot] = '0;
        table_m[slot].id = id;
        return slot;
    endfunction

    function automatic res_t table_step(logic [1:0] f, logic [31:0] id, logic [31:0] t,
                                        logic [15:0] rs, logic [7:0] sn, logic [2:0] hs,
                                        logic [2:0] hl, logic nm, logic [4:0] rk);
        res_t r;
        int   slot;
        int   ahead;
        r = '0;
        if (f == FN_OBSERVE && id != 0) begin
            slot = find_slot(id);
            if (slot < 0) begin
                slot = claim_slot(id);
                r.added = 1'b1;
            end
            table_m[slot].rssi = rs;
            table_m[slot].snr  = sn;
            table_m[slot].seen = t;
            table_m[slot].pkts = table_m[slot].pkts + 1;
            if (hs != 0) begin
                table_m[slot].hops = 8'(hs) - 8'(hl);
                table_m[slot].flags[FLAG_HOPS_BIT] = 1'b1;
            end
        end else if (f == FN_NAME && id != 0) begin
            slot = find_slot(id);
            if (slot < 0) begin
                slot = claim_slot(id);
                table_m[slot].seen = t;
            end
            if (nm) table_m[slot].flags[FLAG_NAMED_BIT] = 1'b1;
        end else if (f == FN_READ && int'(rk) < used_m) begin
            for (int i = 0; i < used_m; i++) begin
                ahead = 0;
                for (int j = 0; j < used_m; j++)
                    if (j != i && (table_m[j].seen > table_m[i].seen ||
                        (table_m[j].seen == table_m[i].seen && j < i)))
                        ahead++;
                if (ahead == int'(rk)) begin
                    r.valid_res = 1'b1;
                    r.rec = table_m[i];
                    break;
                end
            end
        end
        r.occupancy = 6'(used_m);
        return r;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t e;
        if (!rst_n) begin
            used_m = 0;
            errors = 0;
            answers.delete();
        end else begin
            if (in_valid && in_ready)
                answers.push_back(table_step(func, node_id, now_time, rssi_in, snr_in,
                                             hop_origin, hop_remain, name_present,
                                             rank_index));
            if (out_valid && out_ready) begin
                if (answers.size() == 0) begin
                    $display("unexpected result transaction");
                    errors++;
                end else begin
                    e = answers.pop_front();
                    if (added !== e.added) report("added", added, e.added);
                    if (valid_res !== e.valid_res) report("valid_res", valid_res, e.valid_res);
                    if (entry_id !== e.rec.id) report("entry_id", entry_id, e.rec.id);
                    if (entry_rssi !== e.rec.rssi) report("entry_rssi", entry_rssi, e.rec.rssi);
                    if (entry_snr !== e.rec.snr) report("entry_snr", entry_snr, e.rec.snr);
                    if (entry_seen !== e.rec.seen) report("entry_seen", entry_seen, e.rec.seen);
                    if (entry_packets !== e.rec.pkts)
                        report("entry_packets", entry_packets, e.rec.pkts);
                    if (entry_hops !== e.rec.hops) report("entry_hops", entry_hops, e.rec.hops);
                    if (entry_has_hops !== e.rec.flags[FLAG_HOPS_BIT])
                        report("entry_has_hops", entry_has_hops, e.rec.flags[FLAG_HOPS_BIT]);
                    if (entry_named !== e.rec.flags[FLAG_NAMED_BIT])
                        report("entry_named", entry_named, e.rec.flags[FLAG_NAMED_BIT]);
                    if (occupancy !== e.occupancy) report("occupancy", occupancy, e.occupancy);
                end
            end
        end
    end

endmodule

// ===== test/node_table_oldest_eviction_test.sv =====
module node_table_oldest_eviction_test;
    import ntoe_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         func;
    logic [31:0]        node_id;
    logic [31:0]        now_time;
    logic signed [15:0] rssi_in;
    logic signed [7:0]  snr_in;
    logic [2:0]         hop_origin;
    logic [2:0]         hop_remain;
    logic               name_present;
    logic [4:0]         rank_index;
    logic               out_valid;
    logic               out_ready;
    logic               added;
    logic               valid_res;
    logic [31:0]        entry_id;
    logic signed [15:0] entry_rssi;
    logic signed [7:0]  entry_snr;
    logic [31:0]        entry_seen;
    logic [31:0]        entry_packets;
    logic [7:0]         entry_hops;
    logic               entry_has_hops;
    logic               entry_named;
    logic [5:0]         occupancy;
    int                 errors;
    int                 pending;
    int                 idle_cycles;
    bit                 hold_out;
    bit                 stim_done;
    logic [31:0]        clock_ms;
    logic [31:0]        id_pool [48];

    localparam int IDLE_LIMIT = 200000;

    node_table_oldest_eviction i_dut (.*);

    node_table_oldest_eviction_check i_check (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int short_gap();
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 200);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 4);
    endfunction

    // in_valid stays high after acceptance only when the next transaction follows at once
    task automatic send(logic [1:0] f, logic [31:0] id, logic [31:0] t, logic [15:0] rs,
                        logic [7:0] sn, logic [2:0] hs, logic [2:0] hl, logic nm,
                        logic [4:0] rk, int gap);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        func         <= f;
        node_id      <= id;
        now_time     <= t;
        rssi_in      <= rs;
        snr_in       <= sn;
        hop_origin   <= hs;
        hop_remain   <= hl;
        name_present <= nm;
        rank_index   <= rk;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic send_random(int gap);
        int          sel;
        logic [31:0] id;
        logic [31:0] t;
        sel = $urandom_range(0, 99);
        id = ($urandom_range(0, 49) == 0) ? 32'd0 : id_pool[$urandom_range(0, 47)];
        clock_ms = clock_ms + $urandom_range(0, 3);
        t = ($urandom_range(0, 9) == 0) ? $urandom : clock_ms;
        if (sel < 45)
            send(FN_OBSERVE, id, t, 16'($urandom), 8'($urandom), 3'($urandom),
                 3'($urandom), 1'($urandom), 5'($urandom), gap);
        else if (sel < 60)
            send(FN_NAME, id, t, 16'($urandom), 8'($urandom), 3'($urandom),
                 3'($urandom), 1'($urandom), 5'($urandom), gap);
        else if (sel < 97)
            send(FN_READ, $urandom, $urandom, 16'($urandom), 8'($urandom), 3'($urandom),
                 3'($urandom), 1'($urandom), 5'($urandom), gap);
        else
            send(FN_SPARE, $urandom, $urandom, 16'($urandom), 8'($urandom), 3'($urandom),
                 3'($urandom), 1'($urandom), 5'($urandom), gap);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        func = '0;
        node_id = '0;
        now_time = '0;
        rssi_in = '0;
        snr_in = '0;
        hop_origin = '0;
        hop_remain = '0;
        name_present = 1'b0;
        rank_index = '0;
        stim_done = 1'b0;
        hold_out = 1'b0;
        clock_ms = 32'd1000;
        for (int i = 0; i < 48; i++) id_pool[i] = (i < 2) ? 32'hFFFF_FFF0 + i : $urandom | 1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed
        send(FN_READ, 32'd5, 32'd0, 16'd0, 8'd0, 3'd0, 3'd0, 1'b0, 5'd0, 0);
        send(FN_OBSERVE, 32'd0, 32'd9, 16'sh7FFF, 8'sh7F, 3'd7, 3'd0, 1'b1, 5'd0, 0);
        send(FN_OBSERVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'sh7FFF, 8'sh7F, 3'd7, 3'd0,
             1'b0, 5'd31, 0);
        send(FN_OBSERVE, 32'd1, 32'd0, 16'sh8000, 8'sh80, 3'd1, 3'd7, 1'b0, 5'd0, 0);
        send(FN_OBSERVE, 32'd1, 32'd5, 16'shFFFF, 8'shFF, 3'd0, 3'd3, 1'b0, 5'd0, 0);
        send(FN_NAME, 32'd2, 32'd5, 16'd0, 8'd0, 3'd0, 3'd0, 1'b0, 5'd0, 0);
        send(FN_NAME, 32'd2, 32'd99, 16'd0, 8'd0, 3'd0, 3'd0, 1'b1, 5'd0, 0);
        send(FN_NAME, 32'd0, 32'd7, 16'd0, 8'd0, 3'd0, 3'd0, 1'b1, 5'd0, 0);
        send(FN_NAME, 32'hFFFF_FFFF, 32'd7, 16'd0, 8'd0, 3'd0, 3'd0, 1'b1, 5'd0, 0);
        for (int r = 0; r < 5; r++)
            send(FN_READ, 32'd0, 32'd0, 16'd0, 8'd0, 3'd0, 3'd0, 1'b0, 5'(r), 0);
        send(FN_READ, 32'd0, 32'd0, 16'd0, 8'd0, 3'd0, 3'd0, 1'b0, 5'd31, 0);
        send(FN_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'shFFFF, 8'shFF, 3'd7, 3'd7, 1'b1,
             5'd31, 0);
        // sender pause until drained
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        // receiver hold-off while sender keeps offering
        hold_out = 1'b1;
        for (int k = 0; k < 40; k++) send_random(0);
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        for (int k = 0; k < 500; k++) send_random(($urandom_range(0, 3) == 0) ? 0 : short_gap());
        in_valid <= 1'b0;
        stim_done = 1'b1;
    end

    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_out) begin
                out_ready <= 1'b0;
                repeat (3000) @(posedge clk);
                hold_out = 1'b0;
            end
            out_ready <= 1'b1;
            @(posedge clk);
            if ($urandom_range(0, 3) == 0) begin
                out_ready <= 1'b0;
                repeat (short_gap() + 1) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        @(posedge stim_done);
        while (pending != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
